// ===== sv/rnlp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the radix number literal parser.
// Character codes, base constants, prefix tracking enum and digit type; no dependencies.
package rnlp_pkg;

  localparam int RES_WIDTH = 32;
  localparam int CHAR_WIDTH = 7;
  localparam int BASE_WIDTH = 6;

  localparam logic [CHAR_WIDTH-1:0] CH_PCT    = 7'h25;  // '%'
  localparam logic [CHAR_WIDTH-1:0] CH_HASH   = 7'h23;  // '#'
  localparam logic [CHAR_WIDTH-1:0] CH_DOLLAR = 7'h24;  // '$'
  localparam logic [CHAR_WIDTH-1:0] CH_APOS   = 7'h27;  // apostrophe
  localparam logic [CHAR_WIDTH-1:0] CH_0      = 7'h30;
  localparam logic [CHAR_WIDTH-1:0] CH_9      = 7'h39;
  localparam logic [CHAR_WIDTH-1:0] CH_UA     = 7'h41;
  localparam logic [CHAR_WIDTH-1:0] CH_UZ     = 7'h5A;
  localparam logic [CHAR_WIDTH-1:0] CH_LA     = 7'h61;
  localparam logic [CHAR_WIDTH-1:0] CH_LZ     = 7'h7A;

  localparam logic [BASE_WIDTH-1:0] BASE_BIN   = 6'd2;
  localparam logic [BASE_WIDTH-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] BASE_HEX   = 6'd16;
  localparam logic [BASE_WIDTH-1:0] BASE_RST   = 6'd10;
  localparam logic [BASE_WIDTH-1:0] LETTER_OFS = 6'd10;

  localparam logic [2:0] POS_SAT = 3'd4;
  localparam logic [2:0] POS_MID = 3'd1;
  localparam logic [2:0] POS_END = 3'd2;

  // Which prefixes may still follow.
  typedef enum logic [3:0] {
    PFX_START = 4'b0001,
    PFX_BIN   = 4'b0010,
    PFX_DEC   = 4'b0100,
    PFX_DONE  = 4'b1000
  } pfx_t;

  typedef struct packed {
    logic                  ok;   // digit and below the base
    logic [BASE_WIDTH-1:0] val;
  } digit_t;

endpackage

// ===== sv/rnlp_digit.sv =====
`timescale 1ns / 1ps
// Digit decoder: maps an ASCII character to its digit value and checks it against a base.
// Depends on rnlp_pkg.
module rnlp_digit (
  input  logic [rnlp_pkg::CHAR_WIDTH-1:0] character,
  input  logic [rnlp_pkg::BASE_WIDTH-1:0] base,
  output rnlp_pkg::digit_t                digit
);
  import rnlp_pkg::*;

  logic                  is_num;
  logic                  is_upper;
  logic                  is_lower;
  logic [CHAR_WIDTH-1:0] diff;
  logic [BASE_WIDTH-1:0] val;

  always_comb begin
    is_num   = (character >= CH_0)  && (character <= CH_9);
    is_upper = (character >= CH_UA) && (character <= CH_UZ);
    is_lower = (character >= CH_LA) && (character <= CH_LZ);
    if (is_upper) begin
      diff = character - CH_UA;
    end else if (is_lower) begin
      diff = character - CH_LA;
    end else begin
      diff = character - CH_0;
    end
    val = diff[BASE_WIDTH-1:0] + (is_num ? '0 : LETTER_OFS);
    digit.val = val;
    digit.ok  = (is_num || is_upper || is_lower) && (val < base);
  end

endmodule

// ===== sv/radix_number_literal_parser.sv =====
`timescale 1ns / 1ps
// Radix number literal parser, top level.
// Depends on rnlp_pkg and rnlp_digit.
//
// Parses one token, one character per request, and returns one result request per
// token when the character marked last has been taken. Three-character tokens of
// the form 'x' return the code of x. Otherwise optional prefixes '%', '#', '$'
// (each once, in that order, last wins) select base 2, 10 or 16; without a prefix
// the base written through cfg_we/cfg_wdata (reset 10) applies, sampled at the
// first character of each token. Digits 0-9, A-Z, a-z below the base accumulate as
// value*base+digit modulo 2^VALUE_WIDTH; any other character makes the token invalid
// (out_valid_res low, out_value zero). A token of prefixes only gives valid zero.
// The value is sign-extended from VALUE_WIDTH bits and cut to 32 bits.
// Throughput is one character per clock. Each character is held in the input
// register, then a single pass (digit decode, one multiply by the 6-bit base and an
// add) updates the token state and, at the last character, loads the result
// register, which drives the outputs. The input side stalls only when a last
// character meets a full, stalled result register; other characters keep
// flowing. Write the base only while idle.
module radix_number_literal_parser #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [rnlp_pkg::BASE_WIDTH-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rnlp_pkg::CHAR_WIDTH-1:0] in_character,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_valid_res,
  output logic signed [rnlp_pkg::RES_WIDTH-1:0] out_value
);
  import rnlp_pkg::*;

  // configuration
  logic [BASE_WIDTH-1:0]  dflt_base_r;

  // input register
  logic                   s1_valid_r, s1_valid_nxt;
  logic [CHAR_WIDTH-1:0]  s1_char_r;
  logic                   s1_last_r;

  // token state
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic [BASE_WIDTH-1:0]  base_r, base_nxt;
  pfx_t                   stage_r, stage_nxt;
  logic [2:0]             pos_r, pos_nxt;
  logic                   fa_r, fa_nxt;       // first char was an apostrophe
  logic [CHAR_WIDTH-1:0]  mid_r, mid_nxt;
  logic                   bad_r, bad_nxt;

  // result register
  logic                   out_valid_r, out_valid_nxt;
  logic                   res_ok_r;
  logic [RES_WIDTH-1:0]   res_val_r;

  // datapath
  logic                   in_acc;
  logic                   s1_adv;
  logic                   out_free;
  logic [BASE_WIDTH-1:0]  base_cur;
  digit_t                 dig;
  logic [VALUE_WIDTH+BASE_WIDTH-1:0] mac;
  logic                   literal;
  logic signed [VALUE_WIDTH-1:0] acc_s;
  logic [63:0]            acc_ext;
  logic                   res_ok;
  logic [RES_WIDTH-1:0]   res_val;

  // --- handshake ---
  // Non-last characters never produce a result, so they advance regardless of
  // the result side.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --- one character step ---
  // Base latched from the register at the token's first character.
  assign base_cur = (pos_r == '0) ? dflt_base_r : base_r;

  rnlp_digit u_digit (
    .character (s1_char_r),
    .base      (base_cur),
    .digit     (dig)
  );

  assign mac = (VALUE_WIDTH + BASE_WIDTH)'(acc_r) * (VALUE_WIDTH + BASE_WIDTH)'(base_cur)
             + (VALUE_WIDTH + BASE_WIDTH)'(dig.val);

  always_comb begin
    fa_nxt  = (pos_r == '0) ? (s1_char_r == CH_APOS) : fa_r;
    mid_nxt = (pos_r == POS_MID) ? s1_char_r : mid_r;
    literal = s1_last_r && (pos_r == POS_END) && fa_r && (s1_char_r == CH_APOS);
    pos_nxt = (pos_r < POS_SAT) ? pos_r + 3'd1 : pos_r;

    acc_nxt   = acc_r;
    base_nxt  = base_cur;
    stage_nxt = stage_r;
    bad_nxt   = bad_r;
    if ((stage_r == PFX_START) && (s1_char_r == CH_PCT)) begin
      base_nxt  = BASE_BIN;
      stage_nxt = PFX_BIN;
    end else if (((stage_r == PFX_START) || (stage_r == PFX_BIN)) &&
                 (s1_char_r == CH_HASH)) begin
      base_nxt  = BASE_DEC;
      stage_nxt = PFX_DEC;
    end else if ((stage_r != PFX_DONE) && (s1_char_r == CH_DOLLAR)) begin
      base_nxt  = BASE_HEX;
      stage_nxt = PFX_DONE;
    end else begin
      stage_nxt = PFX_DONE;
      if (dig.ok) begin
        acc_nxt = mac[VALUE_WIDTH-1:0];
      end else begin
        bad_nxt = 1'b1;
      end
    end
  end

  // Sign-extend from VALUE_WIDTH, then keep the low 32 bits.
  assign acc_s   = acc_nxt;
  assign acc_ext = 64'(acc_s);

  always_comb begin
    if (literal) begin
      res_ok  = 1'b1;
      res_val = RES_WIDTH'(mid_nxt);
    end else if (bad_nxt) begin
      res_ok  = 1'b0;
      res_val = '0;
    end else begin
      res_ok  = 1'b1;
      res_val = acc_ext[RES_WIDTH-1:0];
    end
  end

  // --- registers ---
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_base_r <= BASE_RST;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      base_r      <= BASE_RST;
      stage_r     <= PFX_START;
      pos_r       <= '0;
      fa_r        <= 1'b0;
      mid_r       <= '0;
      bad_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        dflt_base_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        if (s1_last_r) begin
          // token done: back to a clean start
          acc_r   <= '0;
          base_r  <= dflt_base_r;
          stage_r <= PFX_START;
          pos_r   <= '0;
          fa_r    <= 1'b0;
          mid_r   <= '0;
          bad_r   <= 1'b0;
        end else begin
          acc_r   <= acc_nxt;
          base_r  <= base_nxt;
          stage_r <= stage_nxt;
          pos_r   <= pos_nxt;
          fa_r    <= fa_nxt;
          mid_r   <= mid_nxt;
          bad_r   <= bad_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_character;
      s1_last_r <= in_last;
    end
    if (s1_adv && s1_last_r) begin
      res_ok_r  <= res_ok;
      res_val_r <= res_val;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_valid_res = res_ok_r;
  assign out_value     = res_val_r;

  // --- assertions ---
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_last_r && out_valid_r))
    else $error("input stalled without a blocked last character");

  a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !res_ok_r) |-> (res_val_r == '0))
    else $error("invalid token with nonzero value");

  a_token_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> ((pos_r == '0) && (stage_r == PFX_START) && !bad_r))
    else $error("token state not cleared after last character");

  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_SAT)
    else $error("character position beyond saturation");

  a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> out_valid_r)
    else $error("last character produced no result");

endmodule

// ===== tb/sv/radix_number_literal_parser_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for radix_number_literal_parser (token parser with radix prefixes).
// Depends on rnlp_pkg and the parser RTL; a scoreboard class predicts each token's result.
module radix_number_literal_parser_test;
  import rnlp_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off to back up the parser
  localparam int PHASE_ITEMS  = 250;     // characters per random phase

  // One result request as the parser should return it.
  typedef struct packed {
    logic                        valid_res;
    logic signed [RES_WIDTH-1:0] value;
  } parse_result_t;

  // Scoreboard: runs its own copy of the token state machine on every accepted
  // character request and keeps the results still owed by the parser.
  class token_scoreboard;
    logic [BASE_WIDTH-1:0] default_radix;
    logic [RES_WIDTH-1:0]  acc;
    logic [BASE_WIDTH-1:0] radix;
    pfx_t                  stage;
    logic [2:0]            pos;          // saturates at POS_SAT
    logic                  opens_quote;  // first char was an apostrophe
    logic [CHAR_WIDTH-1:0] mid_char;
    logic                  bad_char;
    parse_result_t         awaited[$];
    int                    errors;

    function new();
      default_radix = BASE_RST;
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      acc = '0;
      radix = default_radix;
      stage = PFX_START;
      pos = '0;
      opens_quote = 1'b0;
      mid_char = '0;
      bad_char = 1'b0;
    endfunction

    function void set_default_radix(logic [BASE_WIDTH-1:0] b);
      default_radix = b;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // 0-9, A-Z, a-z map to 0..35; everything else (':' to '@' included) is no digit.
    function void decode_digit(input logic [CHAR_WIDTH-1:0] c, output logic ok,
                               output logic [BASE_WIDTH-1:0] d);
      ok = 1'b1;
      d = '0;
      if (c >= CH_0 && c <= CH_9) begin
        d = BASE_WIDTH'(c - CH_0);
      end else if (c >= CH_UA && c <= CH_UZ) begin
        d = BASE_WIDTH'(c - CH_UA) + LETTER_OFS;
      end else if (c >= CH_LA && c <= CH_LZ) begin
        d = BASE_WIDTH'(c - CH_LA) + LETTER_OFS;
      end else begin
        ok = 1'b0;
      end
    endfunction

    function void note_request(logic [CHAR_WIDTH-1:0] c, logic last);
      logic                  literal;
      logic                  ok;
      logic [BASE_WIDTH-1:0] d;
      parse_result_t         r;
      // Default base is latched at the first character of a token.
      if (pos == '0) begin
        radix = default_radix;
        opens_quote = (c == CH_APOS);
      end else if (pos == POS_MID) begin
        mid_char = c;
      end
      literal = last && pos == POS_END && opens_quote && c == CH_APOS;

      // Prefixes only in the order '%' '#' '$'; anything else closes the prefix part.
      if (stage == PFX_START && c == CH_PCT) begin
        radix = BASE_BIN;
        stage = PFX_BIN;
      end else if ((stage == PFX_START || stage == PFX_BIN) && c == CH_HASH) begin
        radix = BASE_DEC;
        stage = PFX_DEC;
      end else if (stage != PFX_DONE && c == CH_DOLLAR) begin
        radix = BASE_HEX;
        stage = PFX_DONE;
      end else begin
        stage = PFX_DONE;
        decode_digit(c, ok, d);
        if (!ok || d >= radix) begin
          bad_char = 1'b1;
        end else begin
          acc = acc * RES_WIDTH'(radix) + RES_WIDTH'(d);
        end
      end
      if (pos < POS_SAT) begin
        pos = pos + 3'd1;
      end

      if (last) begin
        if (literal) begin
          r.valid_res = 1'b1;
          r.value = RES_WIDTH'(mid_char);
        end else if (bad_char) begin
          r = '0;
        end else begin
          r.valid_res = 1'b1;
          r.value = acc;
        end
        awaited.push_back(r);
        clear_token();
      end
    endfunction

    function void check_result(logic vr, logic signed [RES_WIDTH-1:0] v);
      parse_result_t e;
      if (awaited.size() == 0) begin
        $error("result with nothing outstanding: valid_res %0b value %0d", vr, v);
        errors++;
        return;
      end
      e = awaited.pop_front();
      if (vr !== e.valid_res) begin
        $error("valid_res: expected %0b, got %0b", e.valid_res, vr);
        errors++;
      end
      if (v !== e.value) begin
        $error("value: expected %0d, got %0d", e.value, v);
        errors++;
      end
    endfunction
  endclass

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [BASE_WIDTH-1:0]       cfg_wdata = BASE_RST;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [CHAR_WIDTH-1:0]       in_character = '0;
  logic                        in_last = 1'b0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_valid_res;
  logic signed [RES_WIDTH-1:0] out_value;

  token_scoreboard       sb;
  logic [CHAR_WIDTH-1:0] tok[$];       // characters of the token being built
  logic [BASE_WIDTH-1:0] cur_radix = BASE_RST;
  int                    tx_idle_pct = 0;
  int                    rx_stall_pct = 0;
  bit                    hold_pending = 1'b0;  // written by stimulus only
  bit                    hold_done = 1'b0;     // written by receiver only
  int                    hold_left = 0;
  int                    cycles = 0;

  radix_number_literal_parser dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_character (in_character),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_valid_res(out_valid_res),
    .out_value    (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: ends the run with an error once the cycle limit is reached.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side. Values read right after the edge are the pre-edge ones, since
  // every testbench drive is nonblocking. One long hold-off when asked for,
  // otherwise random stalls at the current rate.
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        sb.check_result(out_valid_res, out_value);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_pending && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // One character request; holds valid and payload until taken. With no idle
  // drawn, valid simply stays high into the next request.
  task automatic send_request(logic [CHAR_WIDTH-1:0] c, logic last);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_character <= c;
    in_last <= last;
    do @(posedge clk); while (in_stall);
    sb.note_request(c, last);
  endtask

  task automatic send_token();
    for (int i = 0; i < tok.size(); i++) begin
      send_request(tok[i], i == tok.size() - 1);
    end
  endtask

  task automatic run_text(string s);
    logic [7:0] b;
    tok.delete();
    for (int i = 0; i < s.len(); i++) begin
      b = s[i];
      tok.push_back(b[CHAR_WIDTH-1:0]);
    end
    send_token();
  endtask

  // Idle point: input drops, every result is in, and the pipeline has drained.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_radix(logic [BASE_WIDTH-1:0] b);
    wait_quiet();
    cfg_wdata <= b;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_default_radix(b);
    cur_radix = b;
  endtask

  function automatic logic [CHAR_WIDTH-1:0] any_code();
    return CHAR_WIDTH'($urandom_range(127));
  endfunction

  function automatic logic [CHAR_WIDTH-1:0] digit_char(int d);
    if (d < 10) begin
      return CH_0 + CHAR_WIDTH'(d);
    end
    if ($urandom_range(1) == 1) begin
      return CH_UA + CHAR_WIDTH'(d - 10);
    end
    return CH_LA + CHAR_WIDTH'(d - 10);
  endfunction

  // Well-formed number unless the base in force is zero: optional prefixes in order,
  // then digits legal for that base. Long digit runs now and then to exercise the wrap.
  function automatic void add_number();
    logic [BASE_WIDTH-1:0] eff;
    bit                    any_pfx;
    int                    n;
    int                    lim;
    eff = cur_radix;
    any_pfx = 1'b0;
    if ($urandom_range(3) == 0) begin
      tok.push_back(CH_PCT);
      eff = BASE_BIN;
      any_pfx = 1'b1;
    end
    if ($urandom_range(3) == 0) begin
      tok.push_back(CH_HASH);
      eff = BASE_DEC;
      any_pfx = 1'b1;
    end
    if ($urandom_range(3) == 0) begin
      tok.push_back(CH_DOLLAR);
      eff = BASE_HEX;
      any_pfx = 1'b1;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(14, 8) : $urandom_range(6, 0);
    if (!any_pfx && n == 0) begin
      n = 1;
    end
    lim = (eff > 6'd36) ? 36 : int'(eff);
    repeat (n) begin
      if (lim == 0) begin
        tok.push_back(digit_char($urandom_range(9)));  // base zero: nothing is legal
      end else begin
        tok.push_back(digit_char($urandom_range(lim - 1)));
      end
    end
  endfunction

  function automatic void make_random_token();
    int kind;
    int n;
    tok.delete();
    kind = $urandom_range(99);
    if (kind < 55) begin
      add_number();
    end else if (kind < 70) begin
      // character literal, any 7-bit middle code
      tok.push_back(CH_APOS);
      tok.push_back(any_code());
      tok.push_back(CH_APOS);
    end else if (kind < 85) begin
      // number with one character swapped for an arbitrary code
      add_number();
      tok[$urandom_range(tok.size() - 1)] = any_code();
    end else if (kind < 93) begin
      // near misses of a character literal
      case ($urandom_range(2))
        0: begin
          tok.push_back(CH_APOS);
          tok.push_back(any_code());
        end
        1: begin
          tok.push_back(CH_APOS);
          tok.push_back(any_code());
          tok.push_back(CH_APOS);
          tok.push_back(any_code());
        end
        default: begin
          tok.push_back(any_code());
          tok.push_back(any_code());
          tok.push_back(CH_APOS);
        end
      endcase
    end else begin
      // noise, heavy on prefix and quote characters
      n = $urandom_range(5, 1);
      repeat (n) begin
        case ($urandom_range(7))
          0: tok.push_back(CH_PCT);
          1: tok.push_back(CH_HASH);
          2: tok.push_back(CH_DOLLAR);
          3: tok.push_back(CH_APOS);
          default: tok.push_back(any_code());
        endcase
      end
    end
  endfunction

  task automatic run_phase(logic [BASE_WIDTH-1:0] b, int tx_pct, int rx_pct, bit with_hold);
    int sent;
    set_radix(b);
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if (with_hold && sent >= 60) begin
        hold_pending = 1'b1;
      end
      make_random_token();
      send_token();
      sent += tok.size();
    end
  endtask

  initial begin
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed tokens under the reset base of ten.
    run_text("'z'");   // character literal
    run_text("%#$");   // prefixes only: valid zero
    run_text("$fF");   // hex, mixed case
    run_text("9:");    // char between '9' and 'A' is no digit
    run_text("z");     // digit above the base
    run_text("$%");    // prefix out of order
    run_text("'''");   // apostrophe as the literal's middle
    run_text("#");     // lone prefix

    // Degenerate and oversized base register values.
    set_radix(6'd0);
    run_text("0");     // base zero takes no digit
    set_radix(6'd1);
    run_text("00");    // base one takes only zero
    set_radix(6'd63);
    run_text("z9");    // digit set stays 0..35, multiplier is 63

    // Random phases: sender-light idling, receiver-light idling, then flat out
    // with one long receiver hold-off so the parser backs up into its input.
    run_phase(BASE_BIN, 17, 56, 1'b0);
    run_phase(6'd36, 56, 17, 1'b0);
    run_phase(BASE_WIDTH'($urandom_range(63)), 0, 0, 1'b1);

    wait_quiet();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== radix_number_literal_parser.f =====
sv/rnlp_pkg.sv
sv/rnlp_digit.sv
sv/radix_number_literal_parser.sv
tb/sv/radix_number_literal_parser_test.sv
